@@ design/tkfis_pkg.sv @@
// Shared types and constants for the top-k feature index selector.
`timescale 1ns / 1ps
package tkfis_pkg;

  localparam int N_FEATURES_DEF  = 64;
  localparam int MAX_SELECT_DEF  = 16;
  localparam int GENE_W          = 16;
  localparam int FRAC_W          = 15;
  localparam int OUT_IDX_W       = 6;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic {
    MODE_REAL   = 1'b0,
    MODE_BINARY = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    CS_LOAD,
    CS_SORT,
    CS_HAND
  } core_state_t;

  // Classification attached to each queued item
  typedef struct packed {
    logic  feature;
    logic  final_item;
    mode_t mode;
  } item_kind_t;

  // Job handoff from selection core to slot emitter
  typedef struct packed {
    logic valid;
    logic overflow;
  } job_ctl_t;

endpackage

@@ design/tkfis_queue.sv @@
// Small register FIFO between the front end and the selection core.
`timescale 1ns / 1ps
module tkfis_queue
  import tkfis_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ design/tkfis_front.sv @@
// Front end: accepts genes, holds the mode register, numbers and classifies items.
`timescale 1ns / 1ps
module tkfis_front
  import tkfis_pkg::*;
#(
  parameter int N_FEATURES = N_FEATURES_DEF,
  localparam int IDXW = $clog2(N_FEATURES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [GENE_W-1:0] in_gene_value,
  input  logic              in_last,
  input  logic              in_push,
  output logic              in_full,
  input  logic              cfg_we,
  input  logic              cfg_data,
  output logic              q_push,
  input  logic              q_full,
  output item_kind_t        q_kind,
  output logic [GENE_W-1:0] q_gene,
  output logic [IDXW-1:0]   q_idx
);

  localparam int PW = $clog2(N_FEATURES + 1);

  mode_t         mode_r, mode_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          accept, is_feat;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  // Stored genes beyond the feature capacity are dropped
  assign is_feat = (!in_last || (mode_r == MODE_BINARY)) && (pos_r < PW'(N_FEATURES));

  assign q_push            = accept && (is_feat || in_last);
  assign q_kind.feature    = is_feat;
  assign q_kind.final_item = in_last;
  assign q_kind.mode       = mode_r;
  assign q_gene            = in_gene_value;
  assign q_idx             = pos_r[IDXW-1:0];

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    if (cfg_we) begin
      mode_nxt = mode_t'(cfg_data);
    end
    if (accept) begin
      if (in_last) begin
        pos_nxt = '0;
      end else if (is_feat) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_REAL;
      pos_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

@@ design/tkfis_core.sv @@
// Selection core: value-ordered insertion chain, binary pick list, index-ordered result list.
`timescale 1ns / 1ps
module tkfis_core
  import tkfis_pkg::*;
#(
  parameter int N_FEATURES = N_FEATURES_DEF,
  parameter int MAX_SELECT = MAX_SELECT_DEF,
  localparam int IDXW = $clog2(N_FEATURES),
  localparam int CW   = $clog2(MAX_SELECT + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_empty,
  output logic                                  q_pop,
  input  item_kind_t                            q_kind,
  input  logic [GENE_W-1:0]                     q_gene,
  input  logic [IDXW-1:0]                       q_idx,
  output job_ctl_t                              job_ctl,
  input  logic                                  job_ready,
  output logic [CW-1:0]                         job_cnt,
  output logic [MAX_SELECT-1:0][OUT_IDX_W-1:0]  job_idx
);

  localparam int BCW = $clog2(MAX_SELECT + 2);
  localparam int PRW = GENE_W + CW;

  core_state_t       state_r, state_nxt;

  // value chain, largest first, earlier index first among equals
  logic [GENE_W-1:0] ch_val_r [MAX_SELECT];
  logic [GENE_W-1:0] ch_val_nxt [MAX_SELECT];
  logic [IDXW-1:0]   ch_idx_r [MAX_SELECT];
  logic [IDXW-1:0]   ch_idx_nxt [MAX_SELECT];
  logic              ch_vld_r [MAX_SELECT];
  logic              ch_vld_nxt [MAX_SELECT];

  // binary-mode picks in arrival order
  logic [OUT_IDX_W-1:0] bin_idx_r [MAX_SELECT];
  logic [OUT_IDX_W-1:0] bin_idx_nxt [MAX_SELECT];
  logic [BCW-1:0]       bin_cnt_r, bin_cnt_nxt;

  // real-mode picks in index order
  logic [IDXW-1:0]   so_idx_r [MAX_SELECT];
  logic [IDXW-1:0]   so_idx_nxt [MAX_SELECT];
  logic              so_vld_r [MAX_SELECT];
  logic              so_vld_nxt [MAX_SELECT];
  logic [CW-1:0]     so_cnt_r, so_cnt_nxt;

  logic [CW-1:0]     k_r, k_nxt;
  mode_t             mode_r, mode_nxt;

  // per-cell candidates
  logic              beats [MAX_SELECT];
  logic [GENE_W-1:0] ins_val [MAX_SELECT];
  logic [IDXW-1:0]   ins_idx [MAX_SELECT];
  logic              ins_vld [MAX_SELECT];
  logic [GENE_W-1:0] shl_val [MAX_SELECT];
  logic [IDXW-1:0]   shl_idx [MAX_SELECT];
  logic              shl_vld [MAX_SELECT];
  logic              lt [MAX_SELECT];
  logic [IDXW-1:0]   so_ins_idx [MAX_SELECT];
  logic              so_ins_vld [MAX_SELECT];

  logic [PRW-1:0]    k_prod;
  logic [CW:0]       k_quot;
  logic [CW-1:0]     k_calc;

  assign k_prod = PRW'(q_gene) * PRW'(MAX_SELECT);
  assign k_quot = k_prod[PRW-1:FRAC_W];
  assign k_calc = (k_quot >= (CW+1)'(MAX_SELECT)) ? CW'(MAX_SELECT)
                                                 : CW'(k_quot + 1'b1);

  for (genvar i = 0; i < MAX_SELECT; i++) begin : g_cell
    assign beats[i] = !ch_vld_r[i] || (q_gene > ch_val_r[i]);
    assign lt[i]    = so_vld_r[i] && (so_idx_r[i] < ch_idx_r[0]);
    if (i == 0) begin : g_head
      assign ins_val[i]    = beats[i] ? q_gene : ch_val_r[i];
      assign ins_idx[i]    = beats[i] ? q_idx : ch_idx_r[i];
      assign ins_vld[i]    = 1'b1;
      assign so_ins_idx[i] = lt[i] ? so_idx_r[i] : ch_idx_r[0];
      assign so_ins_vld[i] = 1'b1;
    end else begin : g_body
      assign ins_val[i]    = !beats[i] ? ch_val_r[i] :
                             (beats[i-1] ? ch_val_r[i-1] : q_gene);
      assign ins_idx[i]    = !beats[i] ? ch_idx_r[i] :
                             (beats[i-1] ? ch_idx_r[i-1] : q_idx);
      assign ins_vld[i]    = ch_vld_r[i] || ch_vld_r[i-1];
      assign so_ins_idx[i] = lt[i] ? so_idx_r[i] :
                             (lt[i-1] ? ch_idx_r[0] : so_idx_r[i-1]);
      assign so_ins_vld[i] = so_vld_r[i] || so_vld_r[i-1];
    end
    if (i == MAX_SELECT - 1) begin : g_tail
      assign shl_val[i] = ch_val_r[i];
      assign shl_idx[i] = ch_idx_r[i];
      assign shl_vld[i] = 1'b0;
    end else begin : g_mid
      assign shl_val[i] = ch_val_r[i+1];
      assign shl_idx[i] = ch_idx_r[i+1];
      assign shl_vld[i] = ch_vld_r[i+1];
    end
    assign job_idx[i] = (mode_r == MODE_BINARY) ? bin_idx_r[i] : OUT_IDX_W'(so_idx_r[i]);
  end

  assign job_cnt = (mode_r == MODE_REAL) ? so_cnt_r :
                   ((bin_cnt_r > BCW'(MAX_SELECT)) ? CW'(MAX_SELECT) : CW'(bin_cnt_r));

  always_comb begin
    state_nxt      = state_r;
    ch_val_nxt     = ch_val_r;
    ch_idx_nxt     = ch_idx_r;
    ch_vld_nxt     = ch_vld_r;
    bin_idx_nxt    = bin_idx_r;
    bin_cnt_nxt    = bin_cnt_r;
    so_idx_nxt     = so_idx_r;
    so_vld_nxt     = so_vld_r;
    so_cnt_nxt     = so_cnt_r;
    k_nxt          = k_r;
    mode_nxt       = mode_r;
    q_pop          = 1'b0;
    job_ctl.valid    = 1'b0;
    job_ctl.overflow = (mode_r == MODE_BINARY) && (bin_cnt_r > BCW'(MAX_SELECT));
    case (state_r)
      CS_LOAD: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_kind.feature) begin
            ch_val_nxt = ins_val;
            ch_idx_nxt = ins_idx;
            ch_vld_nxt = ins_vld;
            if (q_gene[GENE_W-1]) begin
              for (int j = 0; j < MAX_SELECT; j++) begin
                if (bin_cnt_r == BCW'(j)) begin
                  bin_idx_nxt[j] = OUT_IDX_W'(q_idx);
                end
              end
              // saturate one past the limit to flag the overflow
              if (bin_cnt_r <= BCW'(MAX_SELECT)) begin
                bin_cnt_nxt = bin_cnt_r + 1'b1;
              end
            end
          end
          if (q_kind.final_item) begin
            mode_nxt  = q_kind.mode;
            k_nxt     = k_calc;
            state_nxt = (q_kind.mode == MODE_REAL) ? CS_SORT : CS_HAND;
          end
        end
      end
      CS_SORT: begin
        // move the chain head into the index-ordered list, up to k times
        if ((k_r == '0) || !ch_vld_r[0]) begin
          state_nxt = CS_HAND;
        end else begin
          ch_val_nxt = shl_val;
          ch_idx_nxt = shl_idx;
          ch_vld_nxt = shl_vld;
          so_idx_nxt = so_ins_idx;
          so_vld_nxt = so_ins_vld;
          so_cnt_nxt = so_cnt_r + 1'b1;
          k_nxt      = k_r - 1'b1;
        end
      end
      CS_HAND: begin
        job_ctl.valid = 1'b1;
        if (job_ready) begin
          for (int j = 0; j < MAX_SELECT; j++) begin
            ch_vld_nxt[j] = 1'b0;
            so_vld_nxt[j] = 1'b0;
          end
          so_cnt_nxt  = '0;
          bin_cnt_nxt = '0;
          state_nxt   = CS_LOAD;
        end
      end
      default: begin
        state_nxt = CS_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CS_LOAD;
      bin_cnt_r <= '0;
      so_cnt_r  <= '0;
      for (int j = 0; j < MAX_SELECT; j++) begin
        ch_vld_r[j] <= 1'b0;
        so_vld_r[j] <= 1'b0;
      end
    end else begin
      state_r   <= state_nxt;
      bin_cnt_r <= bin_cnt_nxt;
      so_cnt_r  <= so_cnt_nxt;
      ch_vld_r  <= ch_vld_nxt;
      so_vld_r  <= so_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_val_r  <= ch_val_nxt;
    ch_idx_r  <= ch_idx_nxt;
    bin_idx_r <= bin_idx_nxt;
    so_idx_r  <= so_idx_nxt;
    k_r       <= k_nxt;
    mode_r    <= mode_nxt;
  end

endmodule

@@ design/tkfis_emit.sv @@
// Slot emitter: holds one finished individual and presents its slots in order.
`timescale 1ns / 1ps
module tkfis_emit
  import tkfis_pkg::*;
#(
  parameter int MAX_SELECT = MAX_SELECT_DEF,
  localparam int CW = $clog2(MAX_SELECT + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  job_ctl_t                             job_ctl,
  output logic                                 job_ready,
  input  logic [CW-1:0]                        job_cnt,
  input  logic [MAX_SELECT-1:0][OUT_IDX_W-1:0] job_idx,
  output logic [OUT_IDX_W-1:0]                 out_feature_index,
  output logic                                 out_present,
  output logic                                 out_overflow,
  output logic                                 out_last_slot,
  output logic                                 out_empty,
  input  logic                                 out_pop
);

  logic                 busy_r, busy_nxt;
  logic [CW-1:0]        slot_r, slot_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [OUT_IDX_W-1:0] idx_r [MAX_SELECT];
  logic [OUT_IDX_W-1:0] idx_nxt [MAX_SELECT];
  logic                 take, xfer;

  assign job_ready         = !busy_r;
  assign take              = job_ctl.valid && !busy_r;
  assign xfer              = out_pop && busy_r;
  assign out_empty         = !busy_r;
  assign out_present       = (slot_r < cnt_r);
  assign out_feature_index = out_present ? idx_r[0] : '0;
  assign out_overflow      = ovf_r;
  assign out_last_slot     = (slot_r == CW'(MAX_SELECT - 1));

  always_comb begin
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    idx_nxt  = idx_r;
    if (take) begin
      busy_nxt = 1'b1;
      slot_nxt = '0;
      cnt_nxt  = job_cnt;
      ovf_nxt  = job_ctl.overflow;
      for (int j = 0; j < MAX_SELECT; j++) begin
        idx_nxt[j] = job_idx[j];
      end
    end else if (xfer) begin
      // advance: shift the next slot to the head
      for (int j = 0; j < MAX_SELECT - 1; j++) begin
        idx_nxt[j] = idx_r[j+1];
      end
      slot_nxt = slot_r + 1'b1;
      if (out_last_slot) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    ovf_r <= ovf_nxt;
    idx_r <= idx_nxt;
  end

endmodule

@@ design/top_k_feature_index_select_top.sv @@
// Top level of the top-k feature index selector.
`timescale 1ns / 1ps
// Genes of one individual arrive one per transfer; a feature gene is taken every
// cycle as long as the two-entry item queue drains, since the value-ordered chain
// inserts one gene per cycle. On the last gene (the count gene in real mode) the
// core, in real mode, moves up to k winners (k at most MAX_SELECT) into
// index order, then hands the individual to the emitter, which presents exactly
// MAX_SELECT result slots, one per pop. Genes of the next individual flow in
// while those slots drain; the input reports full only when the queue is full,
// which happens while the core moves winners into index order or waits for the
// emitter to finish the previous individual. encoding_mode is written through
// cfg_we/cfg_data and is sampled when the last gene of an individual is accepted.
module top_k_feature_index_select_top
  import tkfis_pkg::*;
#(
  parameter int N_FEATURES = N_FEATURES_DEF,
  parameter int MAX_SELECT = MAX_SELECT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [GENE_W-1:0]    in_gene_value,
  input  logic                 in_last,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  output logic [OUT_IDX_W-1:0] out_feature_index,
  output logic                 out_present,
  output logic                 out_overflow,
  output logic                 out_last_slot,
  output logic                 out_empty,
  input  logic                 out_pop
);

  localparam int IDXW = $clog2(N_FEATURES);
  localparam int CW   = $clog2(MAX_SELECT + 1);
  localparam int QW   = $bits(item_kind_t) + GENE_W + IDXW;

  logic              fq_push, fq_full;
  item_kind_t        fq_kind, cq_kind;
  logic [GENE_W-1:0] fq_gene, cq_gene;
  logic [IDXW-1:0]   fq_idx, cq_idx;
  logic              cq_pop, cq_empty;
  logic [QW-1:0]     cq_data;

  job_ctl_t                             job_ctl;
  logic                                 job_ready;
  logic [CW-1:0]                        job_cnt;
  logic [MAX_SELECT-1:0][OUT_IDX_W-1:0] job_idx;

  tkfis_front #(
    .N_FEATURES (N_FEATURES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_gene_value (in_gene_value),
    .in_last       (in_last),
    .in_push       (in_push),
    .in_full       (in_full),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .q_push        (fq_push),
    .q_full        (fq_full),
    .q_kind        (fq_kind),
    .q_gene        (fq_gene),
    .q_idx         (fq_idx)
  );

  tkfis_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .wr_data ({fq_kind, fq_gene, fq_idx}),
    .full    (fq_full),
    .pop     (cq_pop),
    .rd_data (cq_data),
    .empty   (cq_empty)
  );

  assign {cq_kind, cq_gene, cq_idx} = cq_data;

  tkfis_core #(
    .N_FEATURES (N_FEATURES),
    .MAX_SELECT (MAX_SELECT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (cq_empty),
    .q_pop     (cq_pop),
    .q_kind    (cq_kind),
    .q_gene    (cq_gene),
    .q_idx     (cq_idx),
    .job_ctl   (job_ctl),
    .job_ready (job_ready),
    .job_cnt   (job_cnt),
    .job_idx   (job_idx)
  );

  tkfis_emit #(
    .MAX_SELECT (MAX_SELECT)
  ) u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_ctl           (job_ctl),
    .job_ready         (job_ready),
    .job_cnt           (job_cnt),
    .job_idx           (job_idx),
    .out_feature_index (out_feature_index),
    .out_present       (out_present),
    .out_overflow      (out_overflow),
    .out_last_slot     (out_last_slot),
    .out_empty         (out_empty),
    .out_pop           (out_pop)
  );

endmodule

@@ design/tkfis_checker.sv @@
// Port-level checks on the result channel of the top-k feature index selector.
`timescale 1ns / 1ps
module tkfis_checker
  import tkfis_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic [OUT_IDX_W-1:0] out_feature_index,
  input logic                 out_present,
  input logic                 out_overflow,
  input logic                 out_last_slot,
  input logic                 out_empty,
  input logic                 out_pop
);

  logic out_xfer;
  assign out_xfer = out_pop && !out_empty;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  a_pad_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_present) |-> (out_feature_index == '0))
    else $error("padding slot with nonzero index");

  a_pad_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !out_present && !out_last_slot) |=> (out_empty || !out_present))
    else $error("feature slot after padding slot");

  a_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !out_last_slot) |=> (out_empty || (out_overflow == $past(out_overflow))))
    else $error("overflow flag changed within an individual");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_overflow) |-> out_present)
    else $error("overflow individual with a padding slot");

endmodule

bind top_k_feature_index_select_top tkfis_checker u_tkfis_checker (.*);
